/* sv/sli_pkg.sv */
// Shared types and codes for the sorted list insert/delete block.
// Used by sli_cell and sorted_list_insert_delete_top; no dependencies.
package sli_pkg;

    localparam int unsigned DATA_W  = 32;
    localparam int unsigned COUNT_W = 5;

    // Operation codes carried in the action field
    typedef enum logic {
        ACT_INSERT = 1'b0,
        ACT_DELETE = 1'b1
    } t_action;

    // Result status codes
    typedef enum logic [1:0] {
        ST_INSERTED  = 2'd0,
        ST_DELETED   = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    // Input word
    typedef struct packed {
        logic                     action;
        logic signed [DATA_W-1:0] value;
    } t_in;

    // Result word
    typedef struct packed {
        logic [1:0]         status;
        logic [COUNT_W-1:0] entry_count;
    } t_out;

    // Per-cell control from the top level
    typedef struct packed {
        logic ins;    // insert accepted this cycle
        logic del;    // delete with a match accepted this cycle
        logic valid;  // cell holds a stored value
        logic tail;   // cell is the first free slot
    } t_cell_ctl;

    // Link handed from a cell to its upper neighbor
    typedef struct packed {
        logic signed [DATA_W-1:0] entry;
        logic                     ge;     // valid and entry >= operand
    } t_link;

endpackage

/* sv/sorted_list_insert_delete_top.sv */
// Sorted list of up to CAPACITY signed 32-bit values kept in ascending order
// in a row of compare-and-shift cells. All cells compare the operand with
// their entry in parallel and shift in the same cycle, so a new word is
// accepted every cycle while the output register is free or being drained,
// and its result word is registered in the output register. An insert lands
// ahead of equal values; a delete removes the first equal value. No clearing
// pass follows reset: the list simply starts empty. entry_count carries the
// low five bits of the count. Depends on sli_pkg and sli_cell.
module sorted_list_insert_delete_top #(
    parameter int unsigned CAPACITY = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  sli_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output sli_pkg::t_out o_data
);

    localparam int unsigned CW = $clog2(CAPACITY + 1);

    logic [CW-1:0]          r_count;
    logic [CW-1:0]          n_count;
    logic                   r_out_valid;
    sli_pkg::t_out          r_out;
    sli_pkg::t_out          n_out;
    logic                   w_accept;
    logic                   w_full;
    logic                   w_found;
    logic                   w_ins;
    logic                   w_del;
    logic [CAPACITY-1:0]    w_eq;
    sli_pkg::t_link         w_link [CAPACITY];

    // Accept when the output register is free or being drained
    assign o_ready  = !r_out_valid || i_ready;
    assign w_accept = i_valid && o_ready;
    assign w_full   = (r_count == CW'(CAPACITY));
    assign w_found  = |w_eq;
    assign w_ins    = w_accept && (i_data.action == sli_pkg::ACT_INSERT) && !w_full;
    assign w_del    = w_accept && (i_data.action == sli_pkg::ACT_DELETE) && w_found;

    // Build the cell chain
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        sli_pkg::t_cell_ctl                w_ctl;
        sli_pkg::t_link                    w_prev;
        logic signed [sli_pkg::DATA_W-1:0] w_next;

        assign w_ctl.ins   = w_ins;
        assign w_ctl.del   = w_del;
        assign w_ctl.valid = (r_count > CW'(g));
        assign w_ctl.tail  = (r_count == CW'(g));

        if (g == 0) begin : g_first
            assign w_prev = '0;
        end else begin : g_mid
            assign w_prev = w_link[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign w_next = '0;
        end else begin : g_inner
            assign w_next = w_link[g+1].entry;
        end

        sli_cell u_cell (
            .i_clk        (i_clk),
            .i_ctl        (w_ctl),
            .i_value      (i_data.value),
            .i_prev       (w_prev),
            .i_next_entry (w_next),
            .o_link       (w_link[g]),
            .o_eq         (w_eq[g])
        );
    end

    // Next count
    always_comb begin
        n_count = r_count;
        if (w_ins) begin
            n_count = r_count + CW'(1);
        end else if (w_del) begin
            n_count = r_count - CW'(1);
        end
    end

    // Form the result word
    always_comb begin
        n_out.entry_count = sli_pkg::COUNT_W'(n_count);
        case (i_data.action)
            sli_pkg::ACT_INSERT: begin
                n_out.status = w_full ? sli_pkg::ST_FULL : sli_pkg::ST_INSERTED;
            end
            sli_pkg::ACT_DELETE: begin
                n_out.status = w_found ? sli_pkg::ST_DELETED : sli_pkg::ST_NOT_FOUND;
            end
            default: begin
                n_out.status = sli_pkg::ST_NOT_FOUND;
            end
        endcase
    end

    // Advance count and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Hold result payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    // Count never exceeds capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("count above capacity");

    // A successful insert grows the list by one
    a_ins_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ins |=> r_count == $past(r_count) + CW'(1))
        else $error("insert did not grow count");

    // A matching delete shrinks the list by one
    a_del_shrink: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_del |=> r_count == $past(r_count) - CW'(1))
        else $error("delete did not shrink count");

    // A refused insert only happens on a full list, which stays full
    a_full_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_data.action == sli_pkg::ACT_INSERT) && w_full)
        |=> (r_count == CW'(CAPACITY)) && (o_data.status == sli_pkg::ST_FULL))
        else $error("full refusal mismatch");

endmodule

/* sv/sli_cell.sv */
// One storage cell of the sorted list chain: compares its entry with the
// operand and shifts up or down with its neighbors. Depends on sli_pkg.
module sli_cell (
    input  logic                              i_clk,
    input  sli_pkg::t_cell_ctl                i_ctl,
    input  logic signed [sli_pkg::DATA_W-1:0] i_value,
    input  sli_pkg::t_link                    i_prev,
    input  logic signed [sli_pkg::DATA_W-1:0] i_next_entry,
    output sli_pkg::t_link                    o_link,
    output logic                              o_eq
);

    logic signed [sli_pkg::DATA_W-1:0] r_entry;
    logic signed [sli_pkg::DATA_W-1:0] n_entry;
    logic                              w_ge;

    // Compare stored entry against the operand
    assign w_ge         = i_ctl.valid && (r_entry >= i_value);
    assign o_eq         = i_ctl.valid && (r_entry == i_value);
    assign o_link.entry = r_entry;
    assign o_link.ge    = w_ge;

    // Select next entry: shift up on insert, shift down on delete
    always_comb begin
        n_entry = r_entry;
        if (i_ctl.ins) begin
            if (i_prev.ge) begin
                n_entry = i_prev.entry;
            end else if (w_ge || i_ctl.tail) begin
                n_entry = i_value;
            end
        end else if (i_ctl.del && w_ge) begin
            n_entry = i_next_entry;
        end
    end

    // Hold entry
    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule
